// ===== sv/dsc_pkg.sv =====
// ---------------------------------------------------------------------------
// Degree sine/cosine unit package
// Shared widths, formats, the quadrant code, the pipeline beat type and the
// CORDIC arctangent table in degrees.
// ---------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 15;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam int ANGLE_W  = 32;
  localparam int RES_W    = 16;
  localparam int XY_W     = 32;
  localparam int Z_FRAC   = 24;
  localparam int XY_FRAC  = 30;
  localparam int ATAN_LEN = 24;
  localparam int REM_W    = 7;

  // Reciprocal of the CORDIC gain of an unbounded number of stages, Q2.30.
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 32'sd652032874;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } dsc_quad_e;

  typedef struct packed {
    logic                   valid;
    dsc_quad_e              quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] z;
  } dsc_cord_t;

  // atan(2^-i) in degrees, Q8.24, rounded to nearest.
  function automatic logic signed [XY_W-1:0] dsc_atan(input int idx);
    logic signed [XY_W-1:0] v;
    case (idx)
      0:  v = 32'sd754974720;
      1:  v = 32'sd445687602;
      2:  v = 32'sd235489088;
      3:  v = 32'sd119537938;
      4:  v = 32'sd60000934;
      5:  v = 32'sd30029717;
      6:  v = 32'sd15018523;
      7:  v = 32'sd7509720;
      8:  v = 32'sd3754917;
      9:  v = 32'sd1877466;
      10: v = 32'sd938734;
      11: v = 32'sd469367;
      12: v = 32'sd234684;
      13: v = 32'sd117342;
      14: v = 32'sd58671;
      15: v = 32'sd29335;
      16: v = 32'sd14668;
      17: v = 32'sd7334;
      18: v = 32'sd3667;
      19: v = 32'sd1833;
      20: v = 32'sd917;
      21: v = 32'sd458;
      22: v = 32'sd229;
      23: v = 32'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dsc_wrap.sv =====
// ---------------------------------------------------------------------------
// Angle reduction
// Three register stages that split the angle into a quadrant and a remainder
// below 90 degrees and seed the CORDIC rotation.
// ---------------------------------------------------------------------------
`default_nettype none

module dsc_wrap #(
  parameter int ANGLE_FRAC_BITS = dsc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                valid_i,
  input  wire  [dsc_pkg::ANGLE_W-1:0]        angle_i,
  output dsc_pkg::dsc_cord_t                 cord_o
);
  import dsc_pkg::*;

  localparam int HW = ANGLE_W - ANGLE_FRAC_BITS;   // whole-degree part
  localparam int UW = HW + 1;                      // offset whole degrees
  // Offset that makes the whole-degree part nonnegative; a multiple of 360
  // so that both the quadrant and the remainder are unchanged.
  localparam longint OFF = 360 * (((longint'(1) << (HW - 1)) + 359) / 360);
  localparam logic signed [UW:0] OFF_S = (UW + 1)'(OFF);
  // Division by 90 as a multiplication by a rounded-up reciprocal; the
  // reciprocal error stays below 1/128 of an LSB, so the quotient is exact.
  localparam int SH = UW + 7;
  localparam int RW = UW + 1;
  localparam int QW = UW - 6;
  localparam longint RECIP = ((longint'(1) << SH) + 89) / 90;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [UW-1:0] NINETY = UW'(90);

  // Stage A: offset the whole-degree part.
  logic                        a_valid_q;
  logic [UW-1:0]               a_u_d, a_u_q;
  logic [ANGLE_FRAC_BITS-1:0]  a_frac_q;
  logic signed [UW:0]          a_sum;

  assign a_sum = $signed({{2{angle_i[ANGLE_W-1]}}, angle_i[ANGLE_W-1:ANGLE_FRAC_BITS]}) + OFF_S;
  assign a_u_d = a_sum[UW-1:0];

  // Stage B: reciprocal product.
  logic                        b_valid_q;
  logic [UW+RW-1:0]            b_prod_q;
  logic [UW-1:0]               b_u_q;
  logic [ANGLE_FRAC_BITS-1:0]  b_frac_q;

  // Stage C: quotient, remainder and CORDIC seed.
  logic                        c_valid_q;
  logic [QW-1:0]               c_quo;
  logic [UW-1:0]               c_rem_full;
  logic [REM_W-1:0]            c_rem;
  dsc_quad_e                   c_quad_q;
  logic signed [XY_W-1:0]      c_z_d, c_z_q;

  assign c_quo      = b_prod_q[SH +: QW];
  assign c_rem_full = b_u_q - UW'(c_quo) * NINETY;
  assign c_rem      = c_rem_full[REM_W-1:0];
  assign c_z_d      = {1'b0, c_rem, b_frac_q, {(Z_FRAC - ANGLE_FRAC_BITS){1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_u_q    <= a_u_d;
    a_frac_q <= angle_i[ANGLE_FRAC_BITS-1:0];
    b_prod_q <= (UW + RW)'(a_u_q) * (UW + RW)'(RECIP_V);
    b_u_q    <= a_u_q;
    b_frac_q <= a_frac_q;
    c_quad_q <= dsc_quad_e'(c_quo[1:0]);
    c_z_q    <= c_z_d;
  end

  assign cord_o.valid = c_valid_q;
  assign cord_o.quad  = c_quad_q;
  assign cord_o.x     = GAIN_Q30;
  assign cord_o.y     = '0;
  assign cord_o.z     = c_z_q;

endmodule

`default_nettype wire

// ===== sv/dsc_cordic_stage.sv =====
// ---------------------------------------------------------------------------
// CORDIC stage
// One registered rotation step with a fixed shift and arctangent constant.
// ---------------------------------------------------------------------------
`default_nettype none

module dsc_cordic_stage #(
  parameter int IDX = 0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire dsc_pkg::dsc_cord_t  in_i,
  output dsc_pkg::dsc_cord_t       out_o
);
  import dsc_pkg::*;

  localparam logic signed [XY_W-1:0] ATAN = dsc_atan(IDX);

  logic                   valid_q;
  dsc_quad_e              quad_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [XY_W-1:0] x_d, y_d, z_d;
  logic signed [XY_W-1:0] x_q, y_q, z_q;

  assign dx = in_i.y >>> IDX;
  assign dy = in_i.x >>> IDX;

  always_comb begin
    if (!in_i.z[XY_W-1]) begin
      x_d = in_i.x - dx;
      y_d = in_i.y + dy;
      z_d = in_i.z - ATAN;
    end else begin
      x_d = in_i.x + dx;
      y_d = in_i.y - dy;
      z_d = in_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= in_i.quad;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign out_o.valid = valid_q;
  assign out_o.quad  = quad_q;
  assign out_o.x     = x_q;
  assign out_o.y     = y_q;
  assign out_o.z     = z_q;

endmodule

`default_nettype wire

// ===== sv/dsc_out.sv =====
// ---------------------------------------------------------------------------
// Output stage
// Rounds and saturates the CORDIC sine and cosine and folds them by quadrant
// into the registered result.
// ---------------------------------------------------------------------------
`default_nettype none

module dsc_out #(
  parameter int OUT_FRAC_BITS = dsc_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire dsc_pkg::dsc_cord_t            in_i,
  output logic                               done_o,
  output logic signed [dsc_pkg::RES_W-1:0]   sine_o,
  output logic signed [dsc_pkg::RES_W-1:0]   cosine_o
);
  import dsc_pkg::*;

  localparam int SHO = XY_FRAC - OUT_FRAC_BITS;
  localparam longint LIM_RAW = (longint'(1) << OUT_FRAC_BITS) - 1;
  localparam longint LIM = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
  localparam logic signed [XY_W:0] LIM_W = (XY_W + 1)'(LIM);
  localparam logic signed [XY_W:0] HALF  = (XY_W + 1)'(longint'(1) << (SHO - 1));

  function automatic logic signed [RES_W-1:0] round_sat(input logic signed [XY_W-1:0] v);
    logic signed [XY_W:0] sum;
    logic signed [XY_W:0] r;
    logic signed [XY_W:0] s;
    sum = $signed({v[XY_W-1], v}) + HALF;
    r   = sum >>> SHO;
    if (r > LIM_W) begin
      s = LIM_W;
    end else if (r < -LIM_W) begin
      s = -LIM_W;
    end else begin
      s = r;
    end
    return s[RES_W-1:0];
  endfunction

  logic signed [RES_W-1:0] s_val, c_val;
  logic signed [RES_W-1:0] sine_d, cosine_d;
  logic                    done_q;
  logic signed [RES_W-1:0] sine_q, cosine_q;

  assign s_val = round_sat(in_i.y);
  assign c_val = round_sat(in_i.x);

  // Magnitudes never exceed 32767, so the negations cannot overflow.
  always_comb begin
    case (in_i.quad)
      QUAD_0: begin
        sine_d   = s_val;
        cosine_d = c_val;
      end
      QUAD_1: begin
        sine_d   = c_val;
        cosine_d = -s_val;
      end
      QUAD_2: begin
        sine_d   = -s_val;
        cosine_d = -c_val;
      end
      default: begin
        sine_d   = -c_val;
        cosine_d = s_val;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q   <= sine_d;
    cosine_q <= cosine_d;
  end

  assign done_o   = done_q;
  assign sine_o   = sine_q;
  assign cosine_o = cosine_q;

endmodule

`default_nettype wire

// ===== sv/degree_sine_cosine_unit_top.sv =====
// ---------------------------------------------------------------------------
// Degree sine/cosine unit
// Sine and cosine of a signed fixed-point angle in degrees, by pipelined
// CORDIC after reduction into a quadrant and a remainder.
// ---------------------------------------------------------------------------
// Usage:
// An angle beat is taken at every rising edge where start_i is high and
// busy_o is low. busy_o is always low: the block is a fully pipelined
// datapath and takes a new angle in every cycle.
// Each result beat appears on sine_o and cosine_o for exactly one cycle with
// done_o high, in the order the angles were taken.
// A beat passes three register stages of angle reduction (offset,
// reciprocal multiply by 1/90, remainder), one register per CORDIC stage,
// and one for rounding, saturation and quadrant folding. Throughput is one
// beat per cycle; the reciprocal multiplier and the per-stage add chain
// set the cycle time.
// The receiver cannot stall; done_o is a plain strobe and must be caught
// when it is high.
// Reset clears the valid bits of every stage, so beats in flight are
// dropped and no done_o strobe follows reset until a new angle is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module degree_sine_cosine_unit_top #(
  parameter int ANGLE_FRAC_BITS = dsc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = dsc_pkg::OUT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES   = dsc_pkg::CORDIC_STAGES_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       start_i,
  output logic                                      busy_o,
  input  wire  signed [dsc_pkg::ANGLE_W-1:0]        angle_i,
  output logic                                      done_o,
  output logic signed [dsc_pkg::RES_W-1:0]          sine_o,
  output logic signed [dsc_pkg::RES_W-1:0]          cosine_o
);
  import dsc_pkg::*;

  localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
  localparam int LAT = NST + 4;

  dsc_cord_t cord [NST+1];

  assign busy_o = 1'b0;

  dsc_wrap #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(start_i && !busy_o),
    .angle_i(angle_i),
    .cord_o (cord[0])
  );

  for (genvar g = 0; g < NST; g++) begin : g_stage
    dsc_cordic_stage #(
      .IDX(g)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .in_i  (cord[g]),
      .out_o (cord[g+1])
    );
  end

  dsc_out #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cord[NST]),
    .done_o  (done_o),
    .sine_o  (sine_o),
    .cosine_o(cosine_o)
  );

`ifndef SYNTH
  // A result beat always goes back to an angle taken with start_i high.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result beat without a matching angle beat");

  // Saturation is symmetric, so the most negative code never appears.
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sine_o != 16'sh8000) && (cosine_o != 16'sh8000))
    else $error("result reached the most negative code");

  // The seed of the rotation carries a remainder below 90 degrees.
  a_seed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord[0].valid |-> !cord[0].z[XY_W-1] && (cord[0].z < (32'sd90 <<< Z_FRAC)))
    else $error("reduced angle outside 0 to 90 degrees");
`endif

endmodule

`default_nettype wire
